// ----- rtl/bin_packing_placer_unit_macros.svh -----
// Assertion macros for the bin packing placer.
`ifndef BIN_PACKING_PLACER_UNIT_MACROS_SVH
`define BIN_PACKING_PLACER_UNIT_MACROS_SVH

// Checked only outside reset.
`define BPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BPP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bpp_pkg.sv -----
// Shared types and constants for the bin packing placer.
package bpp_pkg;

	localparam int VOL_W     = 16;
	localparam int MAX_BINS  = 8;
	localparam int BIN_IDX_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd2;

	typedef enum logic {
		MODE_FIRST_FIT = 1'b0,
		MODE_ROOMIEST  = 1'b1
	} mode_t;

	// What one lane found for its bin
	typedef struct packed {
		logic             fit_ff;
		logic             fit_rf;
		logic [VOL_W-1:0] free;
		logic [VOL_W-1:0] sum;
	} lane_res_t;

	// Winner picked by the merge stage
	typedef struct packed {
		logic                 hit;
		logic [BIN_IDX_W-1:0] idx;
	} pick_t;

endpackage

// ----- rtl/bpp_lane.sv -----
// One bin lane: fit checks and free space for a single bin.
module bpp_lane #(
	parameter int W_BITS = 16
) (
	input  logic [bpp_pkg::VOL_W-1:0] vol,
	input  logic [W_BITS-1:0]         weight,
	input  logic [bpp_pkg::VOL_W-1:0] cap,
	input  logic                      is_open,
	output bpp_pkg::lane_res_t        res
);

	logic [bpp_pkg::VOL_W:0] sum_w;
	logic [bpp_pkg::VOL_W:0] free_w;
	logic [bpp_pkg::VOL_W:0] wt_w;
	logic                    free_pos;

	assign wt_w   = (bpp_pkg::VOL_W+1)'(weight);
	assign sum_w  = (bpp_pkg::VOL_W+1)'(vol) + wt_w;
	// free space may go negative when a bin was opened overfull
	assign free_w = (bpp_pkg::VOL_W+1)'(cap) - (bpp_pkg::VOL_W+1)'(vol);
	assign free_pos = !free_w[bpp_pkg::VOL_W] && (free_w[bpp_pkg::VOL_W-1:0] != '0);

	assign res.fit_ff = is_open && (sum_w <= (bpp_pkg::VOL_W+1)'(cap));
	assign res.fit_rf = is_open && free_pos && (wt_w <= free_w);
	assign res.free   = free_w[bpp_pkg::VOL_W-1:0];
	assign res.sum    = sum_w[bpp_pkg::VOL_W-1:0];

endmodule

// ----- rtl/bpp_merge.sv -----
// Merge stage: picks the winning bin from the lane results.
module bpp_merge #(
	parameter int NUM_BINS = 8
) (
	input  bpp_pkg::lane_res_t lanes [NUM_BINS],
	input  bpp_pkg::mode_t     mode,
	output bpp_pkg::pick_t     pick
);

	bpp_pkg::pick_t            ff_pick;
	bpp_pkg::pick_t            rf_pick;
	logic [bpp_pkg::VOL_W-1:0] best;

	// First fit: lowest lane that fits
	always_comb begin
		ff_pick = '0;
		for (int k = NUM_BINS - 1; k >= 0; k--) begin
			if (lanes[k].fit_ff) begin
				ff_pick.hit = 1'b1;
				ff_pick.idx = bpp_pkg::BIN_IDX_W'(k);
			end
		end
	end

	// Roomiest: largest free space, ties to the lowest lane
	always_comb begin
		rf_pick = '0;
		best    = '0;
		for (int k = 0; k < NUM_BINS; k++) begin
			if (lanes[k].fit_rf && (lanes[k].free > best)) begin
				rf_pick.hit = 1'b1;
				rf_pick.idx = bpp_pkg::BIN_IDX_W'(k);
				best        = lanes[k].free;
			end
		end
	end

	assign pick = (mode == bpp_pkg::MODE_ROOMIEST) ? rf_pick : ff_pick;

endmodule

// ----- rtl/bin_packing_placer_unit.sv -----
// A result beat appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while the output register drains; all bins are checked at once, one lane per bin,
// and the merge plus state update close in that same cycle.
// Input is taken whenever the output register is empty or being drained.
// Reset (arst_n low): all bins empty, no bin open, capacity 65535, first-fit mode,
// bin limit 8, no result pending.
module bin_packing_placer_unit #(
	parameter int NUM_BINS    = 8,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_wr_en,
	input  logic [bpp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpp_pkg::CFG_DATA_W-1:0]      cfg_data,
	// item channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_new_set,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin0,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin1,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin2,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin3,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin4,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin5,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin6,
	input  logic [bpp_pkg::VOL_W-1:0]           weight_bin7,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bpp_pkg::BIN_IDX_W-1:0]       chosen_bin,
	output logic                                opened_bin,
	output logic                                no_bin_left,
	output logic [bpp_pkg::VOL_W-1:0]           bin_volume_after
);

	`include "bin_packing_placer_unit_macros.svh"

	// weight bits actually used per lane
	localparam int WB = (WEIGHT_BITS < bpp_pkg::VOL_W) ? WEIGHT_BITS : bpp_pkg::VOL_W;
	localparam int CNT_W = 4;

	// configuration registers
	logic [bpp_pkg::VOL_W-1:0] cap_q;
	bpp_pkg::mode_t            mode_q;
	logic [CNT_W-1:0]          limit_q;

	// bin state
	logic [bpp_pkg::VOL_W-1:0] vol_q [NUM_BINS];
	logic [CNT_W-1:0]          open_q;

	logic [bpp_pkg::VOL_W-1:0] w_in [bpp_pkg::MAX_BINS];
	logic [bpp_pkg::VOL_W-1:0] vol_eff [NUM_BINS];
	logic [bpp_pkg::VOL_W-1:0] wt_ext [NUM_BINS];
	bpp_pkg::lane_res_t        lane_res [NUM_BINS];
	bpp_pkg::pick_t            pick;

	logic [CNT_W-1:0]          open_eff;
	logic [CNT_W-1:0]          limit_eff;
	logic                      can_open;
	logic                      do_open;
	logic                      in_fire;
	logic [bpp_pkg::VOL_W-1:0] hit_vol;
	logic [bpp_pkg::VOL_W-1:0] new_vol;

	assign w_in[0] = weight_bin0;
	assign w_in[1] = weight_bin1;
	assign w_in[2] = weight_bin2;
	assign w_in[3] = weight_bin3;
	assign w_in[4] = weight_bin4;
	assign w_in[5] = weight_bin5;
	assign w_in[6] = weight_bin6;
	assign w_in[7] = weight_bin7;

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	// a new set sees empty bins and no open bin
	assign open_eff  = start_new_set ? '0 : open_q;
	assign limit_eff = (limit_q > CNT_W'(NUM_BINS)) ? CNT_W'(NUM_BINS) : limit_q;
	assign can_open  = open_eff < limit_eff;
	assign do_open   = !pick.hit && can_open;

	// lanes, one per bin
	for (genvar k = 0; k < NUM_BINS; k++) begin : g_lane
		assign vol_eff[k] = start_new_set ? '0 : vol_q[k];
		assign wt_ext[k]  = bpp_pkg::VOL_W'(w_in[k][WB-1:0]);

		bpp_lane #(
			.W_BITS (WB)
		) u_lane (
			.vol     (vol_eff[k]),
			.weight  (w_in[k][WB-1:0]),
			.cap     (cap_q),
			.is_open (CNT_W'(k) < open_eff),
			.res     (lane_res[k])
		);
	end

	bpp_merge #(
		.NUM_BINS (NUM_BINS)
	) u_merge (
		.lanes (lane_res),
		.mode  (mode_q),
		.pick  (pick)
	);

	// volume of the winning bin and of a newly opened bin
	always_comb begin
		hit_vol = '0;
		new_vol = '0;
		for (int k = 0; k < NUM_BINS; k++) begin
			if (pick.idx == bpp_pkg::BIN_IDX_W'(k)) begin
				hit_vol = lane_res[k].sum;
			end
			if (open_eff == CNT_W'(k)) begin
				new_vol = wt_ext[k];
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= '1;
			mode_q  <= bpp_pkg::MODE_FIRST_FIT;
			limit_q <= CNT_W'(8);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bpp_pkg::REG_CAPACITY: cap_q   <= cfg_data;
				bpp_pkg::REG_MODE:     mode_q  <= bpp_pkg::mode_t'(cfg_data[0]);
				bpp_pkg::REG_LIMIT:    limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// bin state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			for (int k = 0; k < NUM_BINS; k++) begin
				vol_q[k] <= '0;
			end
		end else if (in_fire) begin
			open_q <= do_open ? open_eff + CNT_W'(1) : open_eff;
			for (int k = 0; k < NUM_BINS; k++) begin
				if (pick.hit && (pick.idx == bpp_pkg::BIN_IDX_W'(k))) begin
					vol_q[k] <= lane_res[k].sum;
				end else if (do_open && (open_eff == CNT_W'(k))) begin
					vol_q[k] <= wt_ext[k];
				end else begin
					vol_q[k] <= vol_eff[k];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (pick.hit) begin
				chosen_bin       <= pick.idx;
				opened_bin       <= 1'b0;
				no_bin_left      <= 1'b0;
				bin_volume_after <= hit_vol;
			end else if (do_open) begin
				chosen_bin       <= open_eff[bpp_pkg::BIN_IDX_W-1:0];
				opened_bin       <= 1'b1;
				no_bin_left      <= 1'b0;
				bin_volume_after <= new_vol;
			end else begin
				chosen_bin       <= '0;
				opened_bin       <= 1'b0;
				no_bin_left      <= 1'b1;
				bin_volume_after <= '0;
			end
		end
	end

	// checks
	`BPP_ASSERT_ALWAYS(a_open_bound, open_q <= CNT_W'(NUM_BINS), "open bin count above bin count")
	`BPP_ASSERT(a_drop_clean, (out_valid && no_bin_left) |-> (!opened_bin && (chosen_bin == '0) && (bin_volume_after == '0)), "dropped beat carries data")
	`BPP_ASSERT(a_open_count, (in_valid && in_ready && !start_new_set) |=> (opened_bin == (open_q == ($past(open_q) + CNT_W'(1)))), "open count out of step with opened flag")

endmodule
